>>> rtl/bgi_pkg.sv
// Shared constants, types and helpers for the bilinear grid interpolator.
// No dependencies; imported by the top level, the checker and the testbench.
`default_nettype none

package bgi_pkg;

    // Grid size defaults
    localparam int GRID_X_SIZE_DEF = 256;
    localparam int GRID_Y_SIZE_DEF = 256;

    // Field widths
    localparam int POS_W     = 17;  // signed Q5.12
    localparam int PITCH_W   = 16;  // unsigned Q4.12
    localparam int IDX_W     = 8;
    localparam int SAMPLE_W  = 16;  // Q0.16
    localparam int DENSITY_W = 16;  // Q0.16

    // Scaled coordinate is signed Q10.24
    localparam int PROD_W   = POS_W + PITCH_W + 1;
    localparam int CELL_LSB = 24;
    localparam int FRAC_LSB = 8;
    localparam int FRAC_W   = CELL_LSB - FRAC_LSB;
    localparam int WEIGHT_W = FRAC_W + 1;

    // Blend widths: one axis gives Q0.32, both give Q0.48
    localparam int T_W   = SAMPLE_W + FRAC_W;
    localparam int ACC_W = T_W + FRAC_W;

    // Stream widths
    localparam int S_FIELDS_W = 2 * POS_W + 2 * IDX_W + SAMPLE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((DENSITY_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_AW = 1;
    localparam int CFG_DW = PITCH_W;
    localparam logic [CFG_AW-1:0] REG_INV_PITCH_X = 1'b0;
    localparam logic [CFG_AW-1:0] REG_INV_PITCH_Y = 1'b1;
    localparam logic [PITCH_W-1:0] INV_PITCH_RESET = 16'd41521;

    // Request kinds carried in s_tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Per-query control carried alongside the memory read
    typedef struct packed {
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
        logic              par_x;
        logic              par_y;
        logic              outside;
    } query_ctl_t;

    // Weight of the lower neighbour: 1.0 - f in Q1.16
    function automatic logic [WEIGHT_W-1:0] weight_lo(input logic [FRAC_W-1:0] f);
        return {1'b1, {FRAC_W{1'b0}}} - {1'b0, f};
    endfunction

endpackage

`default_nettype wire

>>> rtl/bilinear_grid_interpolation.sv
// Top level of the bilinear grid interpolator: scaling, four banked grid RAMs,
// two-step weighted blend and output register. Depends on bgi_pkg and bgi_ram.
// Throughput: one word per cycle, writes and queries alike, while no result word
// is stalled; the four corners of a cell sit in four RAM banks split by row and
// column parity. A write is registered in stage A before it reaches the grid
// and is seen by the next query.
// Reset (aresetn low, synchronous) empties the pipeline and restores both pitch
// registers; grid contents are not cleared and are undefined until written.
`default_nettype none

module bilinear_grid_interpolation
    import bgi_pkg::*;
#(
    parameter int GRID_X_SIZE = GRID_X_SIZE_DEF,
    parameter int GRID_Y_SIZE = GRID_Y_SIZE_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_AW-1:0]    cfg_addr,
    input  wire logic [CFG_DW-1:0]    cfg_wdata,
    // input words
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // x_pos[16:0], y_pos[33:17], row[41:34], column[49:42], sample[65:50], zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // req_type[0]
    input  wire logic [0:0]           s_tuser,
    // result words
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // density[15:0]
    output logic [M_TDATA_W-1:0]      m_tdata,
    // outside[0]
    output logic [0:0]                m_tuser
);

    localparam int XH   = (GRID_X_SIZE + 1) / 2;
    localparam int YH   = (GRID_Y_SIZE + 1) / 2;
    localparam int XHW  = (XH > 1) ? $clog2(XH) : 1;
    localparam int YHW  = (YH > 1) ? $clog2(YH) : 1;
    localparam int BANK_DEPTH = XH * YH;
    localparam int AW   = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int HALF_MAX = ((GRID_X_SIZE > GRID_Y_SIZE) ? GRID_X_SIZE : GRID_Y_SIZE) / 2;
    localparam int CW   = $clog2(HALF_MAX + 256) + 1;

    // ---------------------------------------------------------------
    // configuration registers
    logic [PITCH_W-1:0] inv_x_reg, inv_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_x_reg <= INV_PITCH_RESET;
            inv_y_reg <= INV_PITCH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_INV_PITCH_X: inv_x_reg <= cfg_wdata;
                REG_INV_PITCH_Y: inv_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // pipeline control: stall only when a finished result would be overwritten
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, out_valid_reg;
    logic out_valid_next;
    logic stall, adv;

    assign stall    = out_valid_reg & ~m_tready & d_valid_reg;
    assign adv      = ~stall;
    assign s_tready = adv;

    // ---------------------------------------------------------------
    // input unpack and coordinate scaling (one multiplier per axis)
    logic signed [POS_W-1:0]  in_x, in_y;
    logic signed [PROD_W-1:0] px_next, py_next;

    assign in_x    = s_tdata[POS_W-1:0];
    assign in_y    = s_tdata[2*POS_W-1:POS_W];
    assign px_next = in_x * $signed({1'b0, inv_x_reg});
    assign py_next = in_y * $signed({1'b0, inv_y_reg});

    // stage A payload
    logic                     a_type_reg;
    logic signed [PROD_W-1:0] a_px_reg, a_py_reg;
    logic [IDX_W-1:0]         a_row_reg, a_col_reg;
    logic [SAMPLE_W-1:0]      a_sample_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_type_reg   <= s_tuser[0];
            a_px_reg     <= px_next;
            a_py_reg     <= py_next;
            a_row_reg    <= s_tdata[2*POS_W +: IDX_W];
            a_col_reg    <= s_tdata[2*POS_W+IDX_W +: IDX_W];
            a_sample_reg <= s_tdata[2*POS_W+2*IDX_W +: SAMPLE_W];
        end
    end

    // ---------------------------------------------------------------
    // stage A: cell index, fraction, range check and bank addressing
    logic [CW-1:0]      cell_x, cell_y;
    logic               out_x, out_y;
    query_ctl_t         a_ctl;
    logic [XHW-1:0]     hx_base;
    logic [YHW-1:0]     hy_base;
    logic               wr_ok;
    logic [1:0]         wr_bank;
    logic [AW-1:0]      wr_addr;
    logic               a_query, a_write;

    assign cell_x = CW'($signed(a_px_reg[PROD_W-1:CELL_LSB])) + CW'(GRID_X_SIZE / 2);
    assign cell_y = CW'($signed(a_py_reg[PROD_W-1:CELL_LSB])) + CW'(GRID_Y_SIZE / 2);

    // a cell whose upper corner leaves the grid counts as outside
    assign out_x = cell_x[CW-1] | (cell_x >= CW'(GRID_X_SIZE - 1));
    assign out_y = cell_y[CW-1] | (cell_y >= CW'(GRID_Y_SIZE - 1));

    assign a_ctl.fx      = a_px_reg[CELL_LSB-1:FRAC_LSB];
    assign a_ctl.fy      = a_py_reg[CELL_LSB-1:FRAC_LSB];
    assign a_ctl.par_x   = cell_x[0];
    assign a_ctl.par_y   = cell_y[0];
    assign a_ctl.outside = out_x | out_y;

    assign hx_base = cell_x[XHW:1];
    assign hy_base = cell_y[YHW:1];

    assign a_query = a_valid_reg & (a_type_reg == REQ_QUERY);
    assign a_write = a_valid_reg & (a_type_reg == REQ_WRITE);

    // sample write: bank by parity, address by halved indices
    assign wr_ok   = (int'(a_row_reg) < GRID_X_SIZE) && (int'(a_col_reg) < GRID_Y_SIZE);
    assign wr_bank = {a_row_reg[0], a_col_reg[0]};
    assign wr_addr = AW'(int'(a_row_reg[IDX_W-1:1]) * YH + int'(a_col_reg[IDX_W-1:1]));

    // four parity banks; every cell touches each exactly once
    logic [SAMPLE_W-1:0] bank_rdata [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic BX = 1'(b >> 1);
        localparam logic BY = 1'(b & 1);

        logic [XHW-1:0] rx;
        logic [YHW-1:0] ry;
        logic [AW-1:0]  rd_addr;

        // odd cell index: the even-parity neighbour lies one half-row further on
        assign rx      = hx_base + XHW'(cell_x[0] & ~BX);
        assign ry      = hy_base + YHW'(cell_y[0] & ~BY);
        assign rd_addr = AW'(int'(rx) * YH + int'(ry));

        bgi_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .aclk    (aclk),
            .wr_en   (adv & a_write & wr_ok & (wr_bank == 2'(b))),
            .wr_addr (wr_addr),
            .wr_data (a_sample_reg),
            .rd_en   (adv & a_query & ~a_ctl.outside),
            .rd_addr (rd_addr),
            .rd_data (bank_rdata[b])
        );
    end

    // ---------------------------------------------------------------
    // stage B: corners arrive from RAM; blend along y
    query_ctl_t          b_ctl_reg;
    logic [SAMPLE_W-1:0] corner [2][2];
    logic [WEIGHT_W-1:0] wy0, wy1;
    logic [T_W:0]        t_sum [2];

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_ctl_reg <= a_ctl;
        end
    end

    assign wy1 = {1'b0, b_ctl_reg.fy};
    assign wy0 = weight_lo(b_ctl_reg.fy);

    always_comb begin
        for (int dx = 0; dx < 2; dx++) begin
            for (int dy = 0; dy < 2; dy++) begin
                corner[dx][dy] = bank_rdata[{b_ctl_reg.par_x ^ 1'(dx),
                                             b_ctl_reg.par_y ^ 1'(dy)}];
            end
            t_sum[dx] = (T_W+1)'(corner[dx][0] * wy0) + (T_W+1)'(corner[dx][1] * wy1);
        end
    end

    // stage C: blend along x
    logic [T_W-1:0]      c_t0_reg, c_t1_reg;
    logic [FRAC_W-1:0]   c_fx_reg;
    logic                c_outside_reg;
    logic [WEIGHT_W-1:0] wx0, wx1;
    logic [ACC_W:0]      acc_next;

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_t0_reg      <= t_sum[0][T_W-1:0];
            c_t1_reg      <= t_sum[1][T_W-1:0];
            c_fx_reg      <= b_ctl_reg.fx;
            c_outside_reg <= b_ctl_reg.outside;
        end
    end

    assign wx1      = {1'b0, c_fx_reg};
    assign wx0      = weight_lo(c_fx_reg);
    assign acc_next = (ACC_W+1)'(c_t0_reg * wx0) + (ACC_W+1)'(c_t1_reg * wx1);

    // stage D: round half up to Q0.16 and saturate; outside cells give zero
    logic [ACC_W-1:0]          d_acc_reg;
    logic                      d_outside_reg;
    logic [ACC_W:0]            rounded;
    logic [ACC_W-T_W:0]        res_wide;
    logic [DENSITY_W-1:0]      density_next;

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_acc_reg     <= acc_next[ACC_W-1:0];
            d_outside_reg <= c_outside_reg;
        end
    end

    assign rounded  = {1'b0, d_acc_reg} + (ACC_W+1)'({1'b1, {(T_W-1){1'b0}}});
    assign res_wide = rounded[ACC_W:T_W];

    always_comb begin
        if (d_outside_reg) begin
            density_next = '0;
        end else if (res_wide > (ACC_W-T_W+1)'({DENSITY_W{1'b1}})) begin
            density_next = {DENSITY_W{1'b1}};
        end else begin
            density_next = res_wide[DENSITY_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // output register
    logic [DENSITY_W-1:0] out_density_reg;
    logic                 out_outside_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (adv && d_valid_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && d_valid_reg) begin
            out_density_reg <= density_next;
            out_outside_reg <= d_outside_reg;
        end
    end

    // valid bits of the pipeline; writes leave after stage A
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                a_valid_reg <= s_tvalid;
                b_valid_reg <= a_query;
                c_valid_reg <= b_valid_reg;
                d_valid_reg <= c_valid_reg;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_density_reg);
    assign m_tuser  = out_outside_reg;

endmodule

`default_nettype wire

>>> rtl/bgi_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; used for each grid bank.
`default_nettype none

module bgi_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/bgi_checker.sv
// Port-level checks for the bilinear grid interpolator, bound to the top level.
// Depends on bgi_pkg and bilinear_grid_interpolation.
`default_nettype none

module bgi_checker
    import bgi_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [0:0]           m_tuser
);

    // no result word survives a reset
    a_reset_empty: assert property (@(posedge aclk) $past(!aresetn) |-> !m_tvalid)
        else $error("result word visible straight after reset");

    // a waiting result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // a cell outside the grid reports zero density
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("outside result with nonzero density");

    // input back-pressure only comes from a stalled result word
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

endmodule

bind bilinear_grid_interpolation bgi_checker u_bgi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bilinear_grid_interpolation: directed edge cases and
// random write/query traffic, checked against a behavioural shadow of the grid.
// Depends on bgi_pkg and the RTL of the block only.

module tb;
    import bgi_pkg::*;

    localparam int GRID_X         = GRID_X_SIZE_DEF;
    localparam int GRID_Y         = GRID_Y_SIZE_DEF;
    localparam int SETTLE_CYCLES  = 8;     // pipeline is stages A to D plus output register, leave margin
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [DENSITY_W-1:0] density;
        logic                 outside;
    } density_word_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_AW-1:0]    cfg_addr;
    logic [CFG_DW-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    // Shadow of the grid and pitch registers
    logic [SAMPLE_W-1:0] grid_model   [0:GRID_X*GRID_Y-1];
    bit                  grid_written [0:GRID_X*GRID_Y-1];
    logic [PITCH_W-1:0]  pitch_x = INV_PITCH_RESET;
    logic [PITCH_W-1:0]  pitch_y = INV_PITCH_RESET;
    density_word_t       expected_densities [$];

    int send_gap_pct    = 0;
    int sink_stall_pct  = 0;
    int sink_hold       = 0;
    int words_sent      = 0;
    int writes_sent     = 0;
    int queries_sent    = 0;
    int outside_seen    = 0;
    int results_checked = 0;
    int error_count     = 0;
    int quiet_cycles    = 0;

    bilinear_grid_interpolation #(
        .GRID_X_SIZE(GRID_X),
        .GRID_Y_SIZE(GRID_Y)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Scale one coordinate: cell index (offset by half the grid) and Q0.16 fraction
    function automatic void scale_coord(input logic signed [POS_W-1:0] pos,
                                        input logic [PITCH_W-1:0] inv, input int half,
                                        output longint cell_idx,
                                        output logic [FRAC_W-1:0] frac);
        longint prod;
        prod     = longint'(pos) * longint'({1'b0, inv});
        cell_idx = (prod >>> CELL_LSB) + half;
        frac     = prod[CELL_LSB-1:FRAC_LSB];
    endfunction

    // Bilinear blend of the four corners, rounded half up, saturated
    function automatic density_word_t predict_density(input logic signed [POS_W-1:0] x,
                                                      input logic signed [POS_W-1:0] y);
        longint              ix, iy;
        logic [FRAC_W-1:0]   fx, fy;
        longint unsigned     wx0, wx1, wy0, wy1, acc;
        int                  base;
        density_word_t       res;
        scale_coord(x, pitch_x, GRID_X / 2, ix, fx);
        scale_coord(y, pitch_y, GRID_Y / 2, iy, fy);
        res = '0;
        if (ix < 0 || ix >= GRID_X - 1 || iy < 0 || iy >= GRID_Y - 1) begin
            res.outside = 1'b1;
            return res;
        end
        wx1  = fx;
        wx0  = (64'd1 << FRAC_W) - fx;
        wy1  = fy;
        wy0  = (64'd1 << FRAC_W) - fy;
        base = int'(ix) * GRID_Y + int'(iy);
        acc  = grid_model[base] * wx0 * wy0;
        acc += grid_model[base + 1] * wx0 * wy1;
        acc += grid_model[base + GRID_Y] * wx1 * wy0;
        acc += grid_model[base + GRID_Y + 1] * wx1 * wy1;
        acc  = (acc + (64'd1 << 31)) >> 32;
        if (acc > 65535)
            acc = 65535;
        res.density = acc[DENSITY_W-1:0];
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int clamp_index(input int v);
        if (v < 0)
            return 0;
        if (v > 255)
            return 255;
        return v;
    endfunction

    // First cell offset of an 8-cell hot window reachable with this pitch
    function automatic int hot_window(input logic [PITCH_W-1:0] inv);
        int reach;
        reach = inv >> 8;
        if (reach > 120)
            reach = 120;
        return int'($urandom_range(0, 2 * reach)) - reach - 4;
    endfunction

    // Coordinate landing in the hot window, random fraction
    function automatic logic signed [POS_W-1:0] pos_near_cell(input logic [PITCH_W-1:0] inv,
                                                              input int first_cell);
        longint num, q;
        int     target;
        if (inv == 0)
            return POS_W'($urandom);
        target = first_cell + int'($urandom_range(0, 7));
        num    = (longint'(target) <<< CELL_LSB) + longint'($urandom_range(0, 16777215));
        q      = num / longint'({1'b0, inv});
        if (q > 65535)
            q = 65535;
        if (q < -65536)
            q = -65536;
        return q[POS_W-1:0];
    endfunction

    // Send one word and update the shadow when it is taken
    task automatic push_word(input logic kind, input logic signed [POS_W-1:0] x, y,
                             input logic [IDX_W-1:0] r, c, input logic [SAMPLE_W-1:0] smp);
        int            gap;
        density_word_t res;
        gap = idle_len(send_gap_pct);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({smp, c, r, y, x});
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if (kind == REQ_WRITE) begin
            grid_model[int'(r) * GRID_Y + int'(c)]   = smp;
            grid_written[int'(r) * GRID_Y + int'(c)] = 1'b1;
            writes_sent++;
        end else begin
            res = predict_density(x, y);
            expected_densities.push_back(res);
            queries_sent++;
            if (res.outside)
                outside_seen++;
        end
    endtask

    // Query a point, first writing any corner that has never been written
    task automatic issue_query(input logic signed [POS_W-1:0] x, y);
        longint            ix, iy;
        logic [FRAC_W-1:0] fx, fy;
        scale_coord(x, pitch_x, GRID_X / 2, ix, fx);
        scale_coord(y, pitch_y, GRID_Y / 2, iy, fy);
        if (ix >= 0 && ix < GRID_X - 1 && iy >= 0 && iy < GRID_Y - 1) begin
            for (int dx = 0; dx < 2; dx++) begin
                for (int dy = 0; dy < 2; dy++) begin
                    if (!grid_written[int'(ix + dx) * GRID_Y + int'(iy + dy)])
                        push_word(REQ_WRITE, POS_W'($urandom), POS_W'($urandom),
                                  IDX_W'(ix + dx), IDX_W'(iy + dy), SAMPLE_W'($urandom));
                end
            end
        end
        push_word(REQ_QUERY, x, y, IDX_W'($urandom), IDX_W'($urandom), SAMPLE_W'($urandom));
    endtask

    // Hold the sender until every density is back and the pipeline is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_densities.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Both pitch registers on consecutive edges; only while idle
    task automatic set_pitches(input logic [PITCH_W-1:0] px, py);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_INV_PITCH_X;
        cfg_wdata <= px;
        @(posedge aclk);
        pitch_x = px;
        cfg_addr  <= REG_INV_PITCH_Y;
        cfg_wdata <= py;
        @(posedge aclk);
        pitch_y = py;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("mismatch on %s at result %0d: expected %0d, got %0d",
                     field, results_checked, want, got);
    endtask

    // Pitch registers come out of reset at their default
    task automatic test_reset_pitch();
        send_gap_pct   = 0;
        sink_stall_pct = 20;
        issue_query(100, -100);
        issue_query(4096, 8192);
        drain();
    endtask

    // Full-scale corners, write followed at once by a query, zero fraction
    task automatic test_full_scale_and_hazard();
        set_pitches(16'd4096, 16'd4096);    // 1.0: cell offset is pos >> 12
        for (int dx = 0; dx < 2; dx++) begin
            for (int dy = 0; dy < 2; dy++)
                push_word(REQ_WRITE, 0, 0, IDX_W'(128 + dx), IDX_W'(128 + dy), 16'hFFFF);
        end
        issue_query(2049, 4095);
        push_word(REQ_WRITE, 0, 0, 128, 128, 16'h0000);
        issue_query(2049, 4095);
        issue_query(0, 0);
        push_word(REQ_WRITE, 0, 0, 129, 129, SAMPLE_W'($urandom));
        issue_query(4095, 4095);
        drain();
    endtask

    // First and last cells, one past either end, negative exact multiples
    task automatic test_cell_boundaries();
        set_pitches(16'd32768, 16'd32768);  // 8.0: cell offset is pos >> 9
        issue_query(-65536, -65536);
        issue_query(64512, 64512);
        issue_query(65024, 0);
        issue_query(0, 65535);
        issue_query(-512, -1);
        drain();
        set_pitches(16'hFFFF, 16'hFFFF);
        issue_query(-65536, 0);
        issue_query(65535, 65535);
        drain();
    endtask

    // One pitch setting of mixed traffic around a hot window of cells
    task automatic run_traffic_phase(input logic [PITCH_W-1:0] px, py, input int n_words,
                                     input int gap_pct, input int stall_pct,
                                     input bit hold_midway);
        int first_word, win_x, win_y, pick;
        drain();
        set_pitches(px, py);
        send_gap_pct   = gap_pct;
        sink_stall_pct = stall_pct;
        win_x          = hot_window(px);
        win_y          = hot_window(py);
        first_word     = words_sent;
        while (words_sent - first_word < n_words) begin
            if (hold_midway && words_sent - first_word >= n_words / 2) begin
                drain();
                hold_midway = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 12)
                push_word(REQ_WRITE, POS_W'($urandom), POS_W'($urandom),
                          IDX_W'($urandom), IDX_W'($urandom), SAMPLE_W'($urandom));
            else if (pick < 24)
                push_word(REQ_WRITE, POS_W'($urandom), POS_W'($urandom),
                          IDX_W'(clamp_index(win_x + 128 + $urandom_range(0, 8))),
                          IDX_W'(clamp_index(win_y + 128 + $urandom_range(0, 8))),
                          SAMPLE_W'($urandom));
            else if (pick < 40)
                issue_query(POS_W'($urandom), POS_W'($urandom));
            else
                issue_query(pos_near_cell(px, win_x), pos_near_cell(py, win_y));
        end
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(INV_PITCH_RESET, INV_PITCH_RESET, 150, 30, 30, 1'b0);
        run_traffic_phase(16'd4096, 16'd20000, 150, 0, 0, 1'b0);
        run_traffic_phase(16'hFFFF, 16'hFFFF, 150, 50, 50, 1'b1);
        run_traffic_phase(16'd0, 16'd1, 100, 20, 60, 1'b0);
        run_traffic_phase(PITCH_W'($urandom_range(0, 65535)),
                          PITCH_W'($urandom_range(0, 65535)),
                          200, 25, 25, 1'b1);
    endtask

    // Result sink with random back-pressure
    always @(posedge aclk) begin
        int stall;
        if (sink_hold > 0) begin
            m_tready <= 1'b0;
            sink_hold--;
        end else begin
            stall = idle_len(sink_stall_pct);
            m_tready <= (stall == 0);
            if (stall > 0)
                sink_hold = stall - 1;
        end
    end

    // Compare each density word with the oldest prediction
    always @(posedge aclk) begin
        density_word_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            results_checked++;
            if (expected_densities.size() == 0) begin
                report_mismatch("unexpected word", 0, m_tdata[DENSITY_W-1:0]);
            end else begin
                want = expected_densities.pop_front();
                if (m_tdata[DENSITY_W-1:0] !== want.density)
                    report_mismatch("density", want.density, m_tdata[DENSITY_W-1:0]);
                if (m_tuser[0] !== want.outside)
                    report_mismatch("outside", want.outside, m_tuser[0]);
            end
        end
    end

    // Watchdog: too long without any word moving
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d densities outstanding",
                         expected_densities.size());
                $display("bilinear_grid_interpolation verification failed");
                $finish;
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_pitch();
        test_full_scale_and_hazard();
        test_cell_boundaries();
        test_random_traffic();
        drain();

        $display("Sent %0d words: %0d grid writes and %0d queries (%0d outside the grid).",
                 words_sent, writes_sent, queries_sent, outside_seen);
        $display("Checked %0d densities across reset, extreme and random pitch settings.",
                 results_checked);
        if (error_count == 0 && expected_densities.size() == 0) begin
            $display("bilinear_grid_interpolation verification clean");
        end else begin
            $display("%0d mismatches, %0d densities never returned",
                     error_count, expected_densities.size());
            $display("bilinear_grid_interpolation verification failed");
        end
        $finish;
    end

endmodule
